>>> rtl/core/ppau_pkg.sv
// Package for the packed pixel access unit.
// Holds the operation, depth, register and state codes, the shared structs and the
// row stride function. No dependencies.
package ppau_pkg;

  typedef enum logic [1:0] {
    FUNC_RD_COLOUR  = 2'd0,
    FUNC_RD_RAW     = 2'd1,
    FUNC_WR_PIXEL   = 2'd2,
    FUNC_WR_PALETTE = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    DEPTH_1  = 3'd0,
    DEPTH_4  = 3'd1,
    DEPTH_8  = 3'd2,
    DEPTH_16 = 3'd3,
    DEPTH_24 = 3'd4,
    DEPTH_32 = 3'd5
  } depth_e;

  typedef enum logic [1:0] {
    REG_DEPTH   = 2'd0,
    REG_WIDTH   = 2'd1,
    REG_HEIGHT  = 2'd2,
    REG_FLIPPED = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_ADDR,
    S_READ,
    S_MODIFY,
    S_PAL,
    S_DONE
  } state_e;

  // Request to the pixel store; span is the number of bytes of the pixel.
  typedef struct packed {
    logic       rd;
    logic       wr;
    logic [2:0] span;
  } store_req_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       alpha_ok;
  } result_t;

  localparam logic [7:0] BIT_MSB    = 8'h80;
  localparam logic [7:0] NIBBLE_HI  = 8'hF0;
  localparam logic [7:0] NIBBLE_LO  = 8'h0F;
  localparam logic [3:0] RESET_WIDTH_LOG2 = 4'd8;

  // Row stride in bytes: pixel bits of one row rounded up to whole 32-bit words.
  function automatic logic [14:0] stride_of(depth_e depth, logic [12:0] width);
    logic [18:0] bits;
    logic [18:0] words;
    unique case (depth)
      DEPTH_1:  bits = {6'b0, width};
      DEPTH_4:  bits = {4'b0, width, 2'b0};
      DEPTH_8:  bits = {3'b0, width, 3'b0};
      DEPTH_16: bits = {2'b0, width, 4'b0};
      DEPTH_24: bits = {2'b0, width, 4'b0} + {3'b0, width, 3'b0};
      DEPTH_32: bits = {1'b0, width, 5'b0};
      default:  bits = '0;
    endcase
    words = (bits + 19'd31) >> 5;
    return {words[12:0], 2'b00};
  endfunction

endpackage

>>> rtl/core/packed_pixel_access_unit.sv
// Top level of the packed pixel access unit: configuration registers, sequencer,
// palette memory and output register. Depends on ppau_pkg and ppau_pixel_store.
//
// Usage: one request arrives per transfer on the s_axis channel (tuser carries the
// operation, tdata the position, colour and palette slot). Each request gives exactly
// one result transfer on the m_axis channel. Configuration is written through
// cfg_we_i, cfg_index_i and cfg_wdata_i while no request is in flight.
// Sequence: pixel reads, raw reads and pixel writes pass the calc, address, read and
// modify states, and colour reads through the palette add the palette state; a pixel
// outside the image or the store ends after the address state, and a palette write
// after the calc state. The result is loaded into the output register from the done
// state once that register is free. The steps follow from the address multiply, the
// synchronous bank read and the partial-byte write back through the same bank port.
// Reset clears the sequencer and the output register and restores the default
// configuration (8 bit pixels, 256 by 256, rows not flipped); the stores are not
// cleared. When the receiver stalls, the result waits in the output register, the
// next request is still taken, and the sequencer holds its finished result until the
// output register frees.
module packed_pixel_access_unit #(
  parameter int STORE_BYTES     = 65536,
  parameter int PALETTE_ENTRIES = 256,
  parameter int MAX_DIM         = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // column[11:0], row_index[23:12], color_red[31:24], color_green[39:32],
  // color_blue[47:40], alpha_in[55:48], palette_slot[63:56]
  input  logic [63:0] s_axis_tdata,
  // func[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_red[7:0], out_green[15:8], out_blue[23:16], alpha_out[31:24]
  output logic [31:0] m_axis_tdata,
  // in_range[0], alpha_valid[1]
  output logic [1:0]  m_axis_tuser,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_wdata_i
);

  localparam int ADDR_W = $clog2(STORE_BYTES);
  localparam int PAL_W  = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  // Configuration
  ppau_pkg::depth_e depth_q, depth_d;
  logic [12:0]      width_q, width_d;
  logic [12:0]      height_q, height_d;
  logic             flip_q, flip_d;
  logic [14:0]      stride_q;

  // Request held from acceptance to the next one
  ppau_pkg::func_e func_q;
  logic [11:0]     col_q;
  logic [11:0]     row_q;
  logic [7:0]      red_q, green_q, blue_q, alpha_q, slot_q;
  logic [12:0]     srow_q;

  // Address path
  logic [27:0]       prod_q;
  logic [13:0]       coloff_q, coloff_d;
  logic [2:0]        span_q, span_d;
  logic              pos_ok_q, pos_ok_d;
  logic [28:0]       addr_full;
  logic [29:0]       addr_end;
  logic              ok_d, ok_q;
  logic [ADDR_W-1:0] addr_q;

  // Sequencer and result
  ppau_pkg::state_e     state_q, state_d;
  ppau_pkg::store_req_t st_req;
  logic [3:0][7:0]      st_rdata;
  logic [3:0][7:0]      pix_wdata;
  logic [7:0]           pix_idx;
  logic                 pix_indexed;
  logic                 pal_hit;
  ppau_pkg::result_t    pix_res;
  ppau_pkg::result_t    res_q, res_d;
  logic                 pal_we;
  logic                 pal_re;
  logic                 slot_ok;
  logic [23:0]          pal_mem [PALETTE_ENTRIES];
  logic [23:0]          pal_rd_q;
  logic                 accept;
  logic                 out_free;
  logic                 out_load;
  logic                 m_valid_q;
  ppau_pkg::result_t    m_res_q;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ppau_pkg::S_IDLE);

  // Configuration writes
  always_comb begin
    depth_d  = depth_q;
    width_d  = width_q;
    height_d = height_q;
    flip_d   = flip_q;
    if (cfg_we_i) begin
      unique case (ppau_pkg::cfg_reg_e'(cfg_index_i))
        ppau_pkg::REG_DEPTH:   depth_d  = ppau_pkg::depth_e'(cfg_wdata_i[2:0]);
        ppau_pkg::REG_WIDTH:   width_d  = cfg_wdata_i;
        ppau_pkg::REG_HEIGHT:  height_d = cfg_wdata_i;
        ppau_pkg::REG_FLIPPED: flip_d   = cfg_wdata_i[0];
        default:               depth_d  = depth_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q  <= ppau_pkg::DEPTH_8;
      width_q  <= 13'd256;
      height_q <= 13'd256;
      flip_q   <= 1'b0;
      stride_q <= 15'd256;
    end else begin
      depth_q  <= depth_d;
      width_q  <= width_d;
      height_q <= height_d;
      flip_q   <= flip_d;
      stride_q <= ppau_pkg::stride_of(depth_d, width_d);
    end
  end

  // Request registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q  <= ppau_pkg::func_e'(s_axis_tuser);
      col_q   <= s_axis_tdata[11:0];
      row_q   <= s_axis_tdata[23:12];
      red_q   <= s_axis_tdata[31:24];
      green_q <= s_axis_tdata[39:32];
      blue_q  <= s_axis_tdata[47:40];
      alpha_q <= s_axis_tdata[55:48];
      slot_q  <= s_axis_tdata[63:56];
      srow_q  <= flip_q ? (height_q - 13'd1 - {1'b0, s_axis_tdata[23:12]})
                        : {1'b0, s_axis_tdata[23:12]};
    end
  end

  // Column offset, span and position check
  always_comb begin
    unique case (depth_q)
      ppau_pkg::DEPTH_1:  begin coloff_d = {5'b0, col_q[11:3]};        span_d = 3'd1; end
      ppau_pkg::DEPTH_4:  begin coloff_d = {3'b0, col_q[11:1]};        span_d = 3'd1; end
      ppau_pkg::DEPTH_8:  begin coloff_d = {2'b0, col_q};              span_d = 3'd1; end
      ppau_pkg::DEPTH_16: begin coloff_d = {1'b0, col_q, 1'b0};        span_d = 3'd2; end
      ppau_pkg::DEPTH_24: begin
        coloff_d = {1'b0, col_q, 1'b0} + {2'b0, col_q};
        span_d   = 3'd3;
      end
      ppau_pkg::DEPTH_32: begin coloff_d = {col_q, 2'b0};              span_d = 3'd4; end
      default:            begin coloff_d = '0;                         span_d = 3'd0; end
    endcase
    pos_ok_d = (span_d != 3'd0) && ({1'b0, col_q} < width_q) && ({1'b0, row_q} < height_q)
               && ({20'b0, col_q} < 32'(MAX_DIM)) && ({20'b0, row_q} < 32'(MAX_DIM));
  end

  assign addr_full = {1'b0, prod_q} + 29'(coloff_q);
  assign addr_end  = {1'b0, addr_full} + 30'(span_q);
  assign ok_d      = pos_ok_q && (addr_end <= 30'(STORE_BYTES));

  // The request and configuration hold while the sequencer runs, so these settle
  // one stage after another without enables.
  always_ff @(posedge clk_i) begin
    prod_q   <= stride_q * srow_q;
    coloff_q <= coloff_d;
    span_q   <= span_d;
    pos_ok_q <= pos_ok_d;
    ok_q     <= ok_d;
    addr_q   <= addr_full[ADDR_W-1:0];
  end

  ppau_pixel_store #(
    .STORE_BYTES (STORE_BYTES),
    .ADDR_W      (ADDR_W)
  ) u_store (
    .clk_i   (clk_i),
    .req_i   (st_req),
    .addr_i  (addr_q),
    .wdata_i (pix_wdata),
    .rdata_o (st_rdata)
  );

  // Pixel unpacking and packing on the bytes read from the store
  always_comb begin
    logic [7:0] mask;
    mask        = ppau_pkg::BIT_MSB >> col_q[2:0];
    pix_wdata   = st_rdata;
    pix_idx     = st_rdata[0];
    pix_indexed = 1'b1;
    pix_res     = '0;
    pix_res.ok  = 1'b1;
    unique case (depth_q)
      ppau_pkg::DEPTH_1: begin
        pix_idx      = {7'b0, st_rdata[0][3'd7 - col_q[2:0]]};
        pix_wdata[0] = (red_q != 8'd0) ? (st_rdata[0] | mask) : (st_rdata[0] & ~mask);
      end
      ppau_pkg::DEPTH_4: begin
        pix_idx      = col_q[0] ? {4'b0, st_rdata[0][3:0]} : {4'b0, st_rdata[0][7:4]};
        pix_wdata[0] = col_q[0]
                     ? ((st_rdata[0] & ppau_pkg::NIBBLE_HI) | (red_q & ppau_pkg::NIBBLE_LO))
                     : ((st_rdata[0] & ppau_pkg::NIBBLE_LO) | {red_q[3:0], 4'h0});
      end
      ppau_pkg::DEPTH_8: begin
        pix_wdata[0] = red_q;
      end
      ppau_pkg::DEPTH_16: begin
        pix_indexed   = 1'b0;
        pix_wdata[0]  = {green_q[2:0], blue_q[4:0]};
        pix_wdata[1]  = {1'b0, red_q[4:0], green_q[4:3]};
        pix_res.red   = {3'b0, st_rdata[1][6:2]};
        pix_res.green = {3'b0, st_rdata[1][1:0], st_rdata[0][7:5]};
        pix_res.blue  = {3'b0, st_rdata[0][4:0]};
      end
      ppau_pkg::DEPTH_24, ppau_pkg::DEPTH_32: begin
        pix_indexed   = 1'b0;
        pix_wdata     = {alpha_q, red_q, green_q, blue_q};
        pix_res.blue  = st_rdata[0];
        pix_res.green = st_rdata[1];
        pix_res.red   = st_rdata[2];
        if (depth_q == ppau_pkg::DEPTH_32) begin
          pix_res.alpha    = st_rdata[3];
          pix_res.alpha_ok = 1'b1;
        end
      end
      default: begin
        pix_indexed = 1'b0;
      end
    endcase
    if (pix_indexed) begin
      pix_res.red = pix_idx;
    end
  end

  assign pal_hit = pix_indexed && (func_q == ppau_pkg::FUNC_RD_COLOUR)
                   && ({1'b0, pix_idx} < 9'(PALETTE_ENTRIES));
  assign slot_ok = ({1'b0, slot_q} < 9'(PALETTE_ENTRIES));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ppau_pkg::S_IDLE:   if (s_axis_tvalid) state_d = ppau_pkg::S_CALC;
      ppau_pkg::S_CALC:   state_d = (func_q == ppau_pkg::FUNC_WR_PALETTE) ? ppau_pkg::S_DONE
                                                                          : ppau_pkg::S_ADDR;
      ppau_pkg::S_ADDR:   state_d = ok_d ? ppau_pkg::S_READ : ppau_pkg::S_DONE;
      ppau_pkg::S_READ:   state_d = ppau_pkg::S_MODIFY;
      ppau_pkg::S_MODIFY: state_d = ((func_q != ppau_pkg::FUNC_WR_PIXEL) && pal_hit)
                                    ? ppau_pkg::S_PAL : ppau_pkg::S_DONE;
      ppau_pkg::S_PAL:    state_d = ppau_pkg::S_DONE;
      ppau_pkg::S_DONE:   if (out_free) state_d = ppau_pkg::S_IDLE;
      default:            state_d = ppau_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    st_req      = '0;
    st_req.span = span_q;
    pal_we      = 1'b0;
    pal_re      = 1'b0;
    res_d       = res_q;
    out_load    = 1'b0;
    unique case (state_q)
      ppau_pkg::S_CALC: begin
        res_d = '0;
        if (func_q == ppau_pkg::FUNC_WR_PALETTE) begin
          pal_we   = slot_ok;
          res_d.ok = slot_ok;
        end
      end
      ppau_pkg::S_ADDR: begin
        res_d = '0;
      end
      ppau_pkg::S_READ: begin
        st_req.rd = 1'b1;
      end
      ppau_pkg::S_MODIFY: begin
        if (func_q == ppau_pkg::FUNC_WR_PIXEL) begin
          st_req.wr = 1'b1;
          res_d     = '0;
          res_d.ok  = 1'b1;
        end else if (pix_indexed && (func_q == ppau_pkg::FUNC_RD_COLOUR)) begin
          pal_re   = pal_hit;
          res_d    = '0;
          res_d.ok = 1'b1;
        end else begin
          res_d = pix_res;
        end
      end
      ppau_pkg::S_PAL: begin
        res_d.red   = pal_rd_q[23:16];
        res_d.green = pal_rd_q[15:8];
        res_d.blue  = pal_rd_q[7:0];
      end
      ppau_pkg::S_DONE: begin
        out_load = out_free;
      end
      default: begin
        res_d = res_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pal_we) begin
      pal_mem[slot_q[PAL_W-1:0]] <= {red_q, green_q, blue_q};
    end
    if (pal_re) begin
      pal_rd_q <= pal_mem[pix_idx[PAL_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (out_load) begin
      m_res_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ppau_pkg::S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_res_q.alpha, m_res_q.blue, m_res_q.green, m_res_q.red};
  assign m_axis_tuser  = {m_res_q.alpha_ok, m_res_q.ok};

`ifndef SYNTHESIS
  a_write_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_req.wr |-> ok_q)
    else $error("Pixel store written for an access outside the image or store.");

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pal_we && st_req.wr))
    else $error("Palette and pixel store written in the same cycle.");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q == ppau_pkg::S_CALC))
    else $error("Accepted transfer did not start the sequencer.");

  a_read_holds_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_req.rd |=> ((state_q == ppau_pkg::S_MODIFY) && $stable(addr_q)))
    else $error("Store address moved between read and write back.");
`endif

endmodule

>>> rtl/core/ppau_pixel_store.sv
// Byte-addressed pixel store built from four byte-wide banks with registered reads.
// A pixel of up to four bytes at any byte address is read or written in one access.
// Depends on ppau_pkg.
module ppau_pixel_store #(
  parameter int STORE_BYTES = 65536,
  parameter int ADDR_W      = 16
) (
  input  logic                  clk_i,
  input  ppau_pkg::store_req_t  req_i,
  input  logic [ADDR_W-1:0]     addr_i,
  input  logic [3:0][7:0]       wdata_i,
  output logic [3:0][7:0]       rdata_o
);

  localparam int BANK_DEPTH = (STORE_BYTES + 3) / 4;
  localparam int WORD_W     = ADDR_W - 2;

  logic [1:0]        lane;
  logic [WORD_W-1:0] word;
  logic [7:0]        bank_q [4];

  assign lane = addr_i[1:0];
  assign word = addr_i[ADDR_W-1:2];

  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [7:0]        mem [BANK_DEPTH];
    logic [1:0]        offset;
    logic [WORD_W-1:0] index;
    logic              wr_en;

    assign offset = 2'(k) - lane;
    assign index  = word + WORD_W'(2'(k) < lane);
    assign wr_en  = req_i.wr && ({1'b0, offset} < req_i.span);

    always_ff @(posedge clk_i) begin
      if (wr_en) begin
        mem[index] <= wdata_i[offset];
      end
      if (req_i.rd) begin
        bank_q[k] <= mem[index];
      end
    end
  end

  // The address is held from the read to the cycle after, so the lanes rotate back here.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rdata_o[i] = bank_q[2'(i) + lane];
    end
  end

endmodule

>>> tb/pixel_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the packed pixel access unit: follows the configuration port, predicts
// each accepted request from its own copy of the frame store and palette, and compares
// every result transfer in order. Depends on ppau_pkg.
module pixel_result_checker
  import ppau_pkg::*;
#(
  parameter int STORE_BYTES     = 65536,
  parameter int PALETTE_ENTRIES = 256,
  parameter int MAX_DIM         = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [63:0] s_tdata_i,
  input  logic [1:0]  s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [31:0] m_tdata_i,
  input  logic [1:0]  m_tuser_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_wdata_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  logic [7:0]  frame_bytes [STORE_BYTES];
  logic [23:0] palette_colours [PALETTE_ENTRIES];

  depth_e      depth_q;
  logic [12:0] width_q;
  logic [12:0] height_q;
  logic        flip_q;
  int unsigned stride_q;

  result_t     pending_pixel_results [$];
  result_t     expected;
  result_t     observed;
  int unsigned failures = 0;
  int unsigned pending_count = 0;

  assign fail_count_o = failures;
  assign pending_o    = pending_count;

  function automatic int unsigned pixel_bits(depth_e depth);
    case (depth)
      DEPTH_1:  return 1;
      DEPTH_4:  return 4;
      DEPTH_8:  return 8;
      DEPTH_16: return 16;
      DEPTH_24: return 24;
      DEPTH_32: return 32;
      default:  return 0;
    endcase
  endfunction

  function automatic int unsigned padded_row_bytes(depth_e depth, logic [12:0] width);
    return ((width * pixel_bits(depth) + 31) / 32) * 4;
  endfunction

  // Applies one request to the local store and palette and returns its result.
  function automatic result_t pixel_access_outcome(func_e op, logic [11:0] col,
      logic [11:0] row, logic [7:0] red, logic [7:0] green, logic [7:0] blue,
      logic [7:0] alpha, logic [7:0] slot);
    result_t     res;
    int unsigned bits;
    int unsigned srow;
    int unsigned addr;
    int unsigned span;
    int unsigned idx;
    logic [7:0]  cur;
    logic [7:0]  mask;
    logic [15:0] word;
    logic [23:0] entry;
    res  = '0;
    bits = pixel_bits(depth_q);
    if (op == FUNC_WR_PALETTE) begin
      if (slot < PALETTE_ENTRIES) begin
        palette_colours[slot] = {red, green, blue};
        res.ok = 1'b1;
      end
      return res;
    end
    if (bits == 0 || col >= width_q || row >= height_q || col >= MAX_DIM ||
        row >= MAX_DIM) begin
      return res;
    end
    srow = flip_q ? (height_q - 1 - row) : row;
    case (depth_q)
      DEPTH_1: begin
        addr = col >> 3;
        span = 1;
      end
      DEPTH_4: begin
        addr = col >> 1;
        span = 1;
      end
      default: begin
        span = bits / 8;
        addr = col * span;
      end
    endcase
    addr = addr + stride_q * srow;
    if (addr + span > STORE_BYTES) begin
      return res;
    end
    res.ok = 1'b1;
    cur    = frame_bytes[addr];
    if (op == FUNC_WR_PIXEL) begin
      case (depth_q)
        DEPTH_1: begin
          mask = 8'h80 >> col[2:0];
          frame_bytes[addr] = (red != 8'd0) ? (cur | mask) : (cur & ~mask);
        end
        DEPTH_4: begin
          frame_bytes[addr] = col[0] ? {cur[7:4], red[3:0]} : {red[3:0], cur[3:0]};
        end
        DEPTH_8: begin
          frame_bytes[addr] = red;
        end
        DEPTH_16: begin
          word = {1'b0, red[4:0], green[4:0], blue[4:0]};
          frame_bytes[addr]     = word[7:0];
          frame_bytes[addr + 1] = word[15:8];
        end
        default: begin
          frame_bytes[addr]     = blue;
          frame_bytes[addr + 1] = green;
          frame_bytes[addr + 2] = red;
          if (depth_q == DEPTH_32) begin
            frame_bytes[addr + 3] = alpha;
          end
        end
      endcase
    end else if (bits <= 8) begin
      case (depth_q)
        DEPTH_1: idx = cur[7 - col[2:0]];
        DEPTH_4: idx = col[0] ? cur[3:0] : cur[7:4];
        default: idx = cur;
      endcase
      if (op == FUNC_RD_RAW) begin
        res.red = idx[7:0];
      end else if (idx < PALETTE_ENTRIES) begin
        entry     = palette_colours[idx];
        res.red   = entry[23:16];
        res.green = entry[15:8];
        res.blue  = entry[7:0];
      end
    end else if (depth_q == DEPTH_16) begin
      word      = {frame_bytes[addr + 1], cur};
      res.red   = {3'b000, word[14:10]};
      res.green = {3'b000, word[9:5]};
      res.blue  = {3'b000, word[4:0]};
    end else begin
      res.blue  = cur;
      res.green = frame_bytes[addr + 1];
      res.red   = frame_bytes[addr + 2];
      if (depth_q == DEPTH_32) begin
        res.alpha    = frame_bytes[addr + 3];
        res.alpha_ok = 1'b1;
      end
    end
    return res;
  endfunction

  task automatic note_failure(string msg);
    if (failures < 10) begin
      $display("%0t: %s", $realtime, msg);
    end
    failures++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q  = DEPTH_8;
      width_q  = 13'd256;
      height_q = 13'd256;
      flip_q   = 1'b0;
      stride_q = padded_row_bytes(depth_q, width_q);
      pending_pixel_results.delete();
      pending_count = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        observed.ok       = m_tuser_i[0];
        observed.alpha_ok = m_tuser_i[1];
        observed.red      = m_tdata_i[7:0];
        observed.green    = m_tdata_i[15:8];
        observed.blue     = m_tdata_i[23:16];
        observed.alpha    = m_tdata_i[31:24];
        if (pending_pixel_results.size() == 0) begin
          note_failure($sformatf("result transfer with none outstanding: ok=%0b r=%02h g=%02h b=%02h a=%02h av=%0b",
            observed.ok, observed.red, observed.green, observed.blue, observed.alpha,
            observed.alpha_ok));
        end else begin
          expected = pending_pixel_results.pop_front();
          if (observed.ok !== expected.ok || observed.red !== expected.red ||
              observed.green !== expected.green || observed.blue !== expected.blue ||
              observed.alpha !== expected.alpha ||
              observed.alpha_ok !== expected.alpha_ok) begin
            note_failure($sformatf({"result mismatch: expected ok=%0b r=%02h g=%02h b=%02h ",
              "a=%02h av=%0b, got ok=%0b r=%02h g=%02h b=%02h a=%02h av=%0b"},
              expected.ok, expected.red, expected.green, expected.blue, expected.alpha,
              expected.alpha_ok, observed.ok, observed.red, observed.green, observed.blue,
              observed.alpha, observed.alpha_ok));
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        pending_pixel_results.push_back(pixel_access_outcome(func_e'(s_tuser_i),
          s_tdata_i[11:0], s_tdata_i[23:12], s_tdata_i[31:24], s_tdata_i[39:32],
          s_tdata_i[47:40], s_tdata_i[55:48], s_tdata_i[63:56]));
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_DEPTH:   depth_q  = depth_e'(cfg_wdata_i[2:0]);
          REG_WIDTH:   width_q  = cfg_wdata_i;
          REG_HEIGHT:  height_q = cfg_wdata_i;
          REG_FLIPPED: flip_q   = cfg_wdata_i[0];
          default: ;
        endcase
        stride_q = padded_row_bytes(depth_q, width_q);
      end
      pending_count = pending_pixel_results.size();
    end
  end

endmodule

>>> tb/packed_pixel_access_unit_test.sv
`timescale 1ns / 100ps
// Top of the packed pixel access unit testbench: clock, reset, configuration phases and
// request stimulus with random gaps and stalls, plus the final verdict.
// Depends on ppau_pkg, packed_pixel_access_unit and pixel_result_checker.
module packed_pixel_access_unit_test;
  import ppau_pkg::*;

  localparam int STORE_BYTES     = 65536;
  localparam int PALETTE_ENTRIES = 256;
  localparam int MAX_DIM         = 4096;
  localparam int INIT_BYTES      = 512;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int DRAIN_CYCLES    = 32;
  localparam int PHASE_ITEMS     = 30;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [12:0] cfg_wdata_i;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned cycle_count = 0;
  bit          quiet = 1'b0;

  depth_e      cur_depth  = DEPTH_8;
  logic [12:0] cur_width  = 13'd256;
  logic [12:0] cur_height = 13'd256;
  logic        cur_flip   = 1'b0;

  packed_pixel_access_unit #(
    .STORE_BYTES    (STORE_BYTES),
    .PALETTE_ENTRIES(PALETTE_ENTRIES),
    .MAX_DIM        (MAX_DIM)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  pixel_result_checker #(
    .STORE_BYTES    (STORE_BYTES),
    .PALETTE_ENTRIES(PALETTE_ENTRIES),
    .MAX_DIM        (MAX_DIM)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tuser_i   (m_axis_tuser),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fail_count_o(fail_count),
    .pending_o   (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready = quiet || ($urandom_range(0, 99) >= 9);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0, 1:    return 8'h00;
      2:       return 8'hFF;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // True when the request touches no byte that is still unwritten: reads and partial-byte
  // writes must stay inside the initialised region or fall outside the image or the store.
  function automatic bit accessible(func_e op, logic [11:0] col, logic [11:0] row);
    int unsigned span;
    int unsigned bits;
    int unsigned addr;
    int unsigned srow;
    int unsigned stride;
    if (op == FUNC_WR_PALETTE || col >= cur_width || row >= cur_height) begin
      return 1'b1;
    end
    case (cur_depth)
      DEPTH_1:  span = 1;
      DEPTH_4:  span = 1;
      DEPTH_8:  span = 1;
      DEPTH_16: span = 2;
      DEPTH_24: span = 3;
      default:  span = 4;
    endcase
    bits   = (cur_depth == DEPTH_1) ? 1 : (cur_depth == DEPTH_4) ? 4 : span * 8;
    stride = ((cur_width * bits + 31) / 32) * 4;
    srow   = cur_flip ? (cur_height - 1 - row) : row;
    addr   = (cur_depth == DEPTH_1) ? (col >> 3) :
             (cur_depth == DEPTH_4) ? (col >> 1) : col * span;
    addr   = addr + stride * srow;
    if (addr + span > STORE_BYTES) begin
      return 1'b1;
    end
    if (op == FUNC_WR_PIXEL && !(cur_depth inside {DEPTH_1, DEPTH_4})) begin
      return 1'b1;
    end
    return (addr + span <= INIT_BYTES);
  endfunction

  task automatic send_access(func_e op, logic [11:0] col, logic [11:0] row,
      logic [7:0] red, logic [7:0] green, logic [7:0] blue, logic [7:0] alpha,
      logic [7:0] slot);
    while (!quiet && $urandom_range(0, 99) < 9) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {slot, alpha, blue, green, red, row, col};
    s_axis_tuser  = op;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid = 1'b0;
    while (pending_count != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [12:0] value);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_layout(depth_e depth, logic [12:0] width, logic [12:0] height,
      logic flip);
    wait_results_drained();
    cur_depth  = depth;
    cur_width  = width;
    cur_height = height;
    cur_flip   = flip;
    write_reg(REG_DEPTH, {10'd0, depth});
    write_reg(REG_WIDTH, width);
    write_reg(REG_HEIGHT, height);
    write_reg(REG_FLIPPED, {12'd0, flip});
  endtask

  task automatic random_accesses(int count);
    func_e       op;
    logic [11:0] col;
    logic [11:0] row;
    int          sel;
    int          tries;
    bit          found;
    repeat (count) begin
      sel   = $urandom_range(0, 99);
      op    = (sel < 30) ? FUNC_RD_COLOUR : (sel < 50) ? FUNC_RD_RAW :
              (sel < 85) ? FUNC_WR_PIXEL : FUNC_WR_PALETTE;
      found = 1'b0;
      for (tries = 0; tries < 40 && !found; tries++) begin
        case ($urandom_range(0, 4))
          0: begin
            col = $urandom_range(0, 4095);
            row = $urandom_range(0, 4095);
          end
          1: begin
            col = $urandom_range(0, ((cur_width > 128) ? 128 : cur_width) - 1);
            row = cur_flip ? cur_height - 1 : 0;
          end
          default: begin
            col = $urandom_range(0, cur_width);
            row = $urandom_range(0, cur_height - 1);
          end
        endcase
        found = accessible(op, col, row);
      end
      if (!found) begin
        op = FUNC_WR_PALETTE;
      end
      send_access(op, col, row, pick_byte(), pick_byte(), pick_byte(), pick_byte(),
        $urandom_range(0, 255));
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_RD_COLOUR;
    cfg_we_i      = 1'b0;
    cfg_index_i   = REG_DEPTH;
    cfg_wdata_i   = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Fill the palette, then the first store bytes with 32-bit pixels, so later reads
    // only ever see written entries.
    for (int slot = 0; slot < PALETTE_ENTRIES; slot++) begin
      send_access(FUNC_WR_PALETTE, $urandom_range(0, 4095), $urandom_range(0, 4095),
        pick_byte(), pick_byte(), pick_byte(), pick_byte(), slot);
    end
    set_layout(DEPTH_32, 13'd128, 13'd1, 1'b0);
    for (int col = 0; col < 128; col++) begin
      send_access(FUNC_WR_PIXEL, col, 12'd0, pick_byte(), pick_byte(), pick_byte(),
        pick_byte(), $urandom_range(0, 255));
    end

    send_access(FUNC_WR_PIXEL, 12'd127, 12'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_access(FUNC_RD_COLOUR, 12'd127, 12'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_access(FUNC_RD_RAW, 12'd127, 12'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_access(FUNC_WR_PIXEL, 12'd0, 12'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_access(FUNC_RD_COLOUR, 12'd0, 12'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_access(FUNC_RD_COLOUR, 12'd128, 12'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_access(FUNC_WR_PIXEL, 12'd0, 12'd1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_access(FUNC_RD_RAW, 12'd4095, 12'd4095, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_access(FUNC_WR_PALETTE, 12'd4095, 12'd4095, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);

    set_layout(DEPTH_1, 13'd4096, 13'd4096, 1'b1);
    send_access(FUNC_WR_PIXEL, 12'd0, 12'd4095, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00);
    send_access(FUNC_RD_RAW, 12'd0, 12'd4095, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_access(FUNC_WR_PIXEL, 12'd0, 12'd4095, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_access(FUNC_RD_RAW, 12'd0, 12'd4095, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_access(FUNC_RD_COLOUR, 12'd7, 12'd4095, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_access(FUNC_RD_COLOUR, 12'd4095, 12'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    random_accesses(PHASE_ITEMS);

    set_layout(DEPTH_4, 13'd32, 13'd32, 1'b0);
    quiet = 1'b1;
    send_access(FUNC_WR_PIXEL, 12'd0, 12'd0, 8'hAB, 8'h00, 8'h00, 8'h00, 8'h00);
    send_access(FUNC_WR_PIXEL, 12'd1, 12'd0, 8'hF5, 8'h00, 8'h00, 8'h00, 8'h00);
    send_access(FUNC_RD_RAW, 12'd0, 12'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_access(FUNC_RD_COLOUR, 12'd1, 12'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    random_accesses(PHASE_ITEMS);
    quiet = 1'b0;

    set_layout(DEPTH_16, 13'd16, 13'd16, 1'b1);
    send_access(FUNC_WR_PIXEL, 12'd15, 12'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00);
    send_access(FUNC_RD_COLOUR, 12'd15, 12'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    random_accesses(PHASE_ITEMS);

    set_layout(DEPTH_8, 13'd24, 13'd21, 1'b0);
    random_accesses(PHASE_ITEMS);
    set_layout(DEPTH_24, 13'd10, 13'd16, 1'b0);
    random_accesses(PHASE_ITEMS);
    set_layout(DEPTH_32, 13'd4096, 13'd4096, 1'b0);
    random_accesses(PHASE_ITEMS);
    set_layout(DEPTH_8, 13'd1, 13'd1, 1'b1);
    random_accesses(PHASE_ITEMS);
    set_layout(DEPTH_32, 13'd8, 13'd16, 1'b1);
    random_accesses(PHASE_ITEMS);
    set_layout(DEPTH_1, 13'd64, 13'd64, 1'b1);
    random_accesses(PHASE_ITEMS);

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
